// ===== sv/blrc_pkg.sv =====
// shared types, codes and constants for the long-press and auto-repeat key detector
package blrc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NKEYS         = 3;
  localparam int QDEPTH        = 2;
  localparam int CFG_BITS      = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int DELTA_BITS    = 32;

  // key slots, in event output order
  localparam int K_DOWN  = 0;
  localparam int K_UP    = 1;
  localparam int K_POWER = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONGPRESS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE    = 2'd2;

  localparam logic [CFG_BITS-1:0] REPEAT_RST    = 32'd200000000;
  localparam logic [CFG_BITS-1:0] LONGPRESS_RST = 32'd500000000;
  localparam logic [CFG_BITS-1:0] SETTLE_RST    = 32'd10000000;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_PENDING  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_VOL_DOWN = 3'd0,
    EV_VOL_UP   = 3'd1,
    EV_ENTER    = 3'd2,
    EV_S        = 3'd3,
    EV_E        = 3'd4,
    EV_SPACE    = 3'd5
  } event_code_t;

  // code a key sends for its own short press or repeat
  localparam event_code_t KEY_CODE [NKEYS] = '{EV_VOL_DOWN, EV_VOL_UP, EV_ENTER};

  typedef struct packed {
    logic                  vol_down_level;
    logic                  vol_up_level;
    logic                  power_level;
    logic [DELTA_BITS-1:0] delta_ns;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       last_event;
  } out_item_t;

  // events of one tick, one slot per key
  typedef struct packed {
    logic [NKEYS-1:0]        mask;
    event_code_t [NKEYS-1:0] code;
  } bundle_t;

  // queue handshake seen by front and back
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

// ===== sv/blrc_front.sv =====
// front end: takes ticks and config writes, runs the per-key phase machines
module blrc_front #(
  parameter int TIME_BITS = blrc_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  blrc_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [blrc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [blrc_pkg::CFG_BITS-1:0]       cfg_data,
  input  blrc_pkg::q_status_t                 q_stat,
  output logic                                push,
  output blrc_pkg::bundle_t                   push_data
);
  import blrc_pkg::*;

  localparam int CW = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] TOP_W = {{(SW-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

  phase_t                 phase      [NKEYS];
  phase_t                 phase_next [NKEYS];
  logic [TIME_BITS-1:0]   elapsed      [NKEYS];
  logic [TIME_BITS-1:0]   elapsed_next [NKEYS];
  logic [NKEYS-1:0]       rep, rep_next;
  logic [NKEYS-1:0]       lp, lp_next;
  logic                   power_held;
  logic [NKEYS-1:0]       pressed;
  logic [CFG_BITS-1:0]    repeat_interval, longpress, settle;
  logic                   accept;
  bundle_t                bundle;

  assign in_ready  = !q_stat.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign pressed   = {~in_data.power_level, ~in_data.vol_up_level, ~in_data.vol_down_level};

  always_comb begin
    logic [SW-1:0] sum;
    logic [SW-1:0] el;
    bundle = '0;
    sum    = '0;
    el     = '0;
    for (int k = 0; k < NKEYS; k++) begin
      phase_next[k]   = phase[k];
      rep_next[k]     = rep[k];
      lp_next[k]      = lp[k];
      bundle.code[k]  = KEY_CODE[k];
      // saturating time add
      sum = SW'(elapsed[k]) + SW'(in_data.delta_ns);
      el  = (sum > TOP_W) ? TOP_W : sum;
      elapsed_next[k] = el[TIME_BITS-1:0];
      unique case (phase[k])
        PH_RELEASED: begin
          if (pressed[k]) begin
            elapsed_next[k] = '0;
            phase_next[k]   = PH_PRESSED;
          end
        end
        PH_PRESSED: begin
          if (pressed[k]) begin
            if (rep[k] && el >= SW'(repeat_interval)) begin
              bundle.mask[k]  = 1'b1;
              elapsed_next[k] = '0;
            end else if (!lp[k] && el >= SW'(longpress)) begin
              if (k == K_POWER) begin
                bundle.mask[k] = 1'b1;
                bundle.code[k] = pressed[K_DOWN] ? EV_S : (pressed[K_UP] ? EV_E : EV_SPACE);
              end else if (!power_held) begin
                // power level from the previous tick
                bundle.mask[k]  = 1'b1;
                elapsed_next[k] = '0;
                rep_next[k]     = 1'b1;
              end
              lp_next[k] = 1'b1;
            end
          end else begin
            if (!lp[k]) begin
              bundle.mask[k] = 1'b1;
              phase_next[k]  = PH_PENDING;
            end else if (el >= SW'(settle)) begin
              elapsed_next[k] = '0;
              rep_next[k]     = 1'b0;
              lp_next[k]      = 1'b0;
              phase_next[k]   = PH_RELEASED;
            end
          end
        end
        default: begin
          elapsed_next[k] = '0;
          rep_next[k]     = 1'b0;
          lp_next[k]      = 1'b0;
          phase_next[k]   = PH_RELEASED;
        end
      endcase
    end
  end

  assign push      = accept && (|bundle.mask);
  assign push_data = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NKEYS; k++) begin
        phase[k]   <= PH_RELEASED;
        elapsed[k] <= '0;
      end
      rep        <= '0;
      lp         <= '0;
      power_held <= 1'b0;
    end else if (accept) begin
      for (int k = 0; k < NKEYS; k++) begin
        phase[k]   <= phase_next[k];
        elapsed[k] <= elapsed_next[k];
      end
      rep        <= rep_next;
      lp         <= lp_next;
      power_held <= pressed[K_POWER];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_interval <= REPEAT_RST;
      longpress       <= LONGPRESS_RST;
      settle          <= SETTLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REPEAT:    repeat_interval <= cfg_data;
        CFG_LONGPRESS: longpress       <= cfg_data;
        CFG_SETTLE:    settle          <= cfg_data;
        default:       ;
      endcase
    end
  end

  // repeat only ever runs after a long press was seen
  a_rep_needs_lp: assert property (@(posedge clk) disable iff (rst) (rep & ~lp) == '0)
    else $error("repeat active without long press");

  // power never auto-repeats
  a_power_no_rep: assert property (@(posedge clk) disable iff (rst) !rep[K_POWER])
    else $error("power key in repeat");

  // release pending lasts exactly one tick
  for (genvar g = 0; g < NKEYS; g++) begin : g_pend
    a_pending_clears: assert property (@(posedge clk) disable iff (rst)
      (accept && phase[g] == PH_PENDING) |=> phase[g] == PH_RELEASED)
      else $error("release pending did not clear");
  end

endmodule

// ===== sv/blrc_queue.sv =====
// short event-bundle queue between front and back
module blrc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  blrc_pkg::bundle_t   push_data,
  input  logic                pop,
  output blrc_pkg::bundle_t   head,
  output blrc_pkg::q_status_t q_stat
);
  import blrc_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  bundle_t          mem [QDEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNTW-1:0]  count;

  assign q_stat.full     = (count == CNTW'(QDEPTH));
  assign q_stat.nonempty = (count != '0);
  assign head            = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_stat.nonempty)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNTW'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== sv/blrc_back.sv =====
// back end: unpacks one tick's events into single output transactions
module blrc_back (
  input  logic                clk,
  input  logic                rst,
  input  blrc_pkg::q_status_t q_stat,
  input  blrc_pkg::bundle_t   head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output blrc_pkg::out_item_t out_data
);
  import blrc_pkg::*;

  localparam int SELW = $clog2(NKEYS);

  logic [NKEYS-1:0]        rem, rem_after;
  event_code_t [NKEYS-1:0] cur;
  logic [SELW-1:0]         sel;
  logic                    emit;

  // lowest pending slot first, which keeps key order
  always_comb begin
    sel = '0;
    for (int k = NKEYS - 1; k >= 0; k--) begin
      if (rem[k]) begin
        sel = SELW'(k);
      end
    end
    rem_after      = rem;
    rem_after[sel] = 1'b0;
  end

  assign emit = (|rem) && (!out_valid || out_ready);
  assign pop  = q_stat.nonempty && ((rem == '0) || (emit && rem_after == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        rem <= head.mask;
      end else if (emit) begin
        rem <= rem_after;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.code;
    end
    if (emit) begin
      out_data.event_code <= cur[sel];
      out_data.last_event <= (rem_after == '0);
    end
  end

  // a taken event that is not the last of its tick is followed at once
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last_event) |=> out_valid)
    else $error("gap inside event burst");

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst) emit |-> rem != '0)
    else $error("emit without pending event");

  a_pop_loads_work: assert property (@(posedge clk) disable iff (rst) pop |=> rem != '0)
    else $error("loaded an empty bundle");

endmodule

// ===== sv/button_longpress_repeat_combo_top.sv =====
// top level of the long-press, auto-repeat and combo key detector
// usage:
//   input channel (in_valid/in_ready/in_data): one transaction per tick, carrying the
//   three active-low key levels and the nanoseconds since the previous tick
//   output channel (out_valid/out_ready/out_data): zero to three event transactions
//   per tick, in key order (volume down, volume up, power); last_event marks the
//   final event of a tick, a tick that causes no event produces nothing
//   config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index 0
//   repeat interval, 1 long-press time, 2 release settle time, other indexes ignored;
//   write only while the block is idle
// timing:
//   all three key machines update in the single cycle a tick is accepted; the first
//   event of that tick then passes the bundle queue, rem/cur and the output register
//   the back end sends one event per cycle while out_ready is high; ticks are accepted
//   every cycle while the two-entry bundle queue has room
// reset (rst, synchronous): keys released, timers and flags cleared, registers
//   back to 200 ms, 500 ms and 10 ms; queue and output register emptied
// stall: when out_ready is low the output register holds its event, bundles
//   pile up in the queue, and in_ready drops once the queue is full
module button_longpress_repeat_combo_top #(
  parameter int TIME_BITS = blrc_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  blrc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output blrc_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [blrc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [blrc_pkg::CFG_BITS-1:0]     cfg_data
);
  import blrc_pkg::*;

  // front to queue
  logic      push;
  bundle_t   push_data;
  // queue to back
  logic      pop;
  bundle_t   head;
  q_status_t q_stat;

  // key phase machines and config registers
  blrc_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // decouples tick acceptance from event delivery
  blrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // serializer with registered output
  blrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
